### sv/slcm_pkg.sv
// Shared types, constants and the keyword compare function of the serial line command matcher.
package slcm_pkg;

	localparam int LINE_DEPTH = 10;
	localparam int FILL_W     = $clog2(LINE_DEPTH + 1);
	localparam int KW_CHARS   = 8;
	localparam int KW_W       = 8 * KW_CHARS;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_BS = 8'h08;

	localparam logic [KW_W-1:0] KW_FIRST_RESET  = 64'h0000_0054_5241_5453;
	localparam logic [KW_W-1:0] KW_SECOND_RESET = 64'h0000_0000_504F_5453;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_KW_FIRST  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_KW_SECOND = 2'd1;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic [1:0] kind_t;
	localparam kind_t KIND_BYTE    = 2'd0;
	localparam kind_t KIND_MATCH   = 2'd1;
	localparam kind_t KIND_NOMATCH = 2'd2;

	typedef logic [LINE_DEPTH-1:0][7:0] line_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] tx_byte;
		logic       keyword_index;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic    valid;
		logic    two;
		result_t first;
		result_t second;
	} result_pair_t;

	function automatic logic kw_match(input logic [KW_W-1:0] kw, input line_t line,
		input logic [FILL_W-1:0] n);
		logic       ok;
		logic       stopped;
		logic [7:0] k;
		logic [7:0] b;
		ok      = 1'b1;
		stopped = 1'b0;
		for (int i = 0; i < LINE_DEPTH; i++) begin
			k = 8'd0;
			if (i < KW_CHARS) begin
				k = kw[(i % KW_CHARS) * 8 +: 8];
			end
			b = line[i];
			if (FILL_W'(i) < n && !stopped) begin
				if (k != b) begin
					ok      = 1'b0;
					stopped = 1'b1;
				end else if (k == 8'd0) begin
					stopped = 1'b1;
				end
			end
		end
		return ok;
	endfunction

endpackage

### sv/slcm_line.sv
// Input register, line store, fill count, keyword registers and per-item result logic.
module slcm_line
	import slcm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [KW_W-1:0]      wr_data,
	input  logic                 space,
	output result_pair_t         pair
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [FILL_W-1:0] fill_q;
	line_t             line_q;
	logic [KW_W-1:0]   kw_first_q;
	logic [KW_W-1:0]   kw_second_q;
	logic              process;
	logic              end_line;
	logic              is_bs;
	logic              match_first;
	logic              match_second;

	assign process  = valid_s1 && space;
	assign in_ready = !valid_s1 || space;
	assign end_line = (fill_q >= FILL_W'(LINE_DEPTH)) || (byte_s1 == CHAR_CR);
	assign is_bs    = byte_s1 == CHAR_BS;

	assign match_first  = kw_match(kw_first_q, line_q, fill_q);
	assign match_second = kw_match(kw_second_q, line_q, fill_q);

	always_comb begin
		pair.valid               = process;
		pair.two                 = end_line || is_bs;
		pair.first.kind          = KIND_BYTE;
		pair.first.tx_byte       = byte_s1;
		pair.first.keyword_index = 1'b0;
		pair.first.last_of_run   = !(end_line || is_bs);
		pair.second.kind          = KIND_BYTE;
		pair.second.tx_byte       = 8'd0;
		pair.second.keyword_index = 1'b0;
		pair.second.last_of_run   = 1'b1;
		if (end_line) begin
			if (match_first) begin
				pair.second.kind = KIND_MATCH;
			end else if (match_second) begin
				pair.second.kind          = KIND_MATCH;
				pair.second.keyword_index = 1'b1;
			end else begin
				pair.second.kind = KIND_NOMATCH;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_first_q  <= KW_FIRST_RESET;
			kw_second_q <= KW_SECOND_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_KW_FIRST) begin
				kw_first_q <= wr_data;
			end else if (wr_index == REG_KW_SECOND) begin
				kw_second_q <= wr_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			line_q <= '0;
		end else if (process) begin
			if (end_line) begin
				fill_q <= '0;
				line_q <= '0;
			end else if (is_bs) begin
				if (fill_q != '0) begin
					fill_q <= fill_q - FILL_W'(1);
					for (int i = 0; i < LINE_DEPTH; i++) begin
						if (FILL_W'(i + 1) == fill_q) begin
							line_q[i] <= 8'd0;
						end
					end
				end
			end else begin
				fill_q <= fill_q + FILL_W'(1);
				for (int i = 0; i < LINE_DEPTH; i++) begin
					if (FILL_W'(i) == fill_q) begin
						line_q[i] <= byte_s1;
					end
				end
			end
		end
	end

endmodule

### sv/slcm_queue.sv
// Result queue that takes one or two results per item and hands out one per cycle while out_ready is high.
module slcm_queue
	import slcm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  result_pair_t pair,
	output logic         space,
	output logic         out_valid,
	input  logic         out_ready,
	output result_t      out_result
);

	result_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   count_q;
	logic                 pop;
	logic [Q_CNT_W-1:0]   push_n;
	logic [Q_PTR_W-1:0]   wr_ptr_next;

	assign space       = count_q <= Q_CNT_W'(Q_DEPTH - 2);
	assign out_valid   = count_q != '0;
	assign pop         = out_valid && out_ready;
	assign out_result  = mem_q[rd_ptr_q];
	assign wr_ptr_next = wr_ptr_q + Q_PTR_W'(1);

	always_comb begin
		push_n = '0;
		if (pair.valid) begin
			push_n = pair.two ? Q_CNT_W'(2) : Q_CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[Q_PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			count_q <= count_q + push_n - (pop ? Q_CNT_W'(1) : Q_CNT_W'(0));
		end
	end

	always_ff @(posedge clk) begin
		if (pair.valid) begin
			mem_q[wr_ptr_q] <= pair.first;
			if (pair.two) begin
				mem_q[wr_ptr_next] <= pair.second;
			end
		end
	end

endmodule

### sv/serial_line_command_matcher.sv
// Top level of the serial line command matcher.
// Each received byte is echoed; a backspace also yields a zero byte, and a carriage
// return or a byte arriving on a full line ends the line and yields a match result
// (first keyword, second keyword or none) after the echo. Bytes pass the input register
// into a four-entry result queue that hands out one result item per cycle while
// m_tready is high; a byte is taken every cycle while the queue has space. Keywords
// are written through the wr_* port; the user must do so only while the block is idle,
// which the block does not enforce. Indexes other than 0 and 1 are ignored.
module serial_line_command_matcher
	import slcm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [7:0] rx_byte
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,  // [7:0] tx_byte, [8] keyword_index, rest zero
	output logic [1:0]           m_tuser,  // [1:0] kind
	output logic                 m_tlast,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [KW_W-1:0]      wr_data
);

	result_pair_t pair;
	logic         space;
	result_t      head;

	slcm_line u_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.space    (space),
		.pair     (pair)
	);

	slcm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.pair       (pair),
		.space      (space),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (head)
	);

	assign m_tdata = {7'd0, head.keyword_index, head.tx_byte};
	assign m_tuser = head.kind;
	assign m_tlast = head.last_of_run;

endmodule
